>>> rtl/rast_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rast_pkg: shared types and constants for the range assign / range sum tree
// node entry layout, field widths and the sequencer state encoding
// ----------------------------------------------------------------------------
package rast_pkg;

	localparam int unsigned SUM_W       = 42;
	localparam int unsigned VAL_W       = 32;
	localparam int unsigned LEFT_W      = 10;
	localparam int unsigned RIGHT_W     = 11;
	localparam int unsigned S_DATA_W    = 56;
	localparam int unsigned M_DATA_W    = 48;
	localparam int unsigned LEAVES_DEF  = 1024;

	localparam logic CMD_QUERY  = 1'b0;
	localparam logic CMD_ASSIGN = 1'b1;

	// one tree node: pending tag and subtree sum
	typedef struct packed {
		logic             valid;
		logic [VAL_W-1:0] tag;
		logic [SUM_W-1:0] sum;
	} node_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_PUSH_RD,
		ST_PUSH_CHK,
		ST_PUSH_W1,
		ST_PUSH_W2,
		ST_WALK_L,
		ST_WALK_R,
		ST_FIX_RD,
		ST_FIX_CHK,
		ST_FIX_C0,
		ST_FIX_C1,
		ST_RESULT
	} state_t;

endpackage

>>> rtl/rast_node_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rast_node_ram: node store of the tree
// one write port and one read port with registered read data
// ----------------------------------------------------------------------------
module rast_node_ram #(
	parameter int unsigned AW = 11
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [AW-1:0]        waddr,
	input  rast_pkg::node_t      wdata,
	input  logic                 re,
	input  logic [AW-1:0]        raddr,
	output rast_pkg::node_t      rdata
);
	import rast_pkg::*;

	node_t mem_q [0:(1<<AW)-1];
	node_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> rtl/range_assign_range_sum_tree_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// range_assign_range_sum_tree_core: lazy segment tree, range assign and sum
// bottom-up tree with pending tags held in one node memory
// ----------------------------------------------------------------------------
// sequence: push-down of pending tags over both boundary paths, then the range
//   walk, then, for an assign only, the upward fix over both paths
// throughput: one transaction at a time, set by the single node memory port pair
// empty ranges skip the tree: an assign returns to idle, a query goes to the result
// reset: arst_n clears control at once, then a clearing pass over all 2*LEAVES
//   node addresses zeroes the node memory while s_tready stays low
// ----------------------------------------------------------------------------
module range_assign_range_sum_tree_core #(
	parameter int unsigned LEAVES = rast_pkg::LEAVES_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// slave side
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// left_index [9:0], right_end [20:10], assign_value [52:21]
	input  logic [rast_pkg::S_DATA_W-1:0]  s_tdata,
	// command (0 query, 1 assign)
	input  logic                           s_tuser,
	// master side
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// range_sum [41:0]
	output logic [rast_pkg::M_DATA_W-1:0]  m_tdata
);
	import rast_pkg::*;

	localparam int unsigned LW = $clog2(LEAVES);   // leaf level
	localparam int unsigned AW = LW + 1;           // node address
	localparam int unsigned NW = LW + 2;           // index, holds 2*LEAVES
	localparam int unsigned SW = $clog2(LW + 1);   // level counter
	localparam int unsigned CW = 18;               // clamp compare width

	// value times a power-of-two length, wraps like the sum
	function automatic logic [SUM_W-1:0] scaled(input logic [VAL_W-1:0] v,
			input logic [SW-1:0] sh);
		logic [SUM_W-1:0] ext;
		ext = {{(SUM_W-VAL_W){v[VAL_W-1]}}, v};
		return ext << sh;
	endfunction

	// input fields
	logic [LEFT_W-1:0]  in_left;
	logic [RIGHT_W-1:0] in_right;
	logic [VAL_W-1:0]   in_val;
	logic [CW-1:0]      lo_x, hi_x, lo_c, hi_c;
	logic               s_hs;

	assign in_left  = s_tdata[LEFT_W-1:0];
	assign in_right = s_tdata[LEFT_W+RIGHT_W-1:LEFT_W];
	assign in_val   = s_tdata[LEFT_W+RIGHT_W+VAL_W-1:LEFT_W+RIGHT_W];
	assign lo_x     = CW'(in_left);
	assign hi_x     = CW'(in_right);
	assign lo_c     = (lo_x > CW'(LEAVES)) ? CW'(LEAVES) : lo_x;
	assign hi_c     = (hi_x > CW'(LEAVES)) ? CW'(LEAVES) : hi_x;
	assign s_hs     = s_tvalid && s_tready;

	// sequencer state
	state_t            state_q, state_d;
	logic [AW-1:0]     clr_q;
	logic              cmd_q;
	logic [VAL_W-1:0]  val_q;
	logic [NW-1:0]     l0_q, r0m1_q;       // boundary leaves
	logic [NW-1:0]     k_q;                // path node
	logic [SW-1:0]     s_q;                // push shift
	logic              pass_q;             // second boundary path
	logic [NW-1:0]     l_q, r_q;           // walk bounds
	logic [SW-1:0]     t_q;                // walk level from leaves
	logic              acc_pend_q;
	logic [SUM_W-1:0]  acc_q, fix_a_q;
	logic              m_tvalid_q;
	logic [SUM_W-1:0]  m_sum_q;

	// memory side
	logic              mem_we, mem_re;
	logic [AW-1:0]     mem_waddr, mem_raddr;
	node_t             mem_wdata, mem_rdata;

	// push parent and next step control
	logic [NW-1:0]     push_p;
	logic              push_adv;
	logic              push_done;
	logic              walk_rd;
	logic              fix_adv;
	logic              res_load;

	assign push_p    = k_q >> s_q;
	assign push_done = (s_q == SW'(1)) && pass_q;
	assign res_load  = (state_q == ST_RESULT) && (!m_tvalid_q || m_tready);

	rast_node_ram #(
		.AW (AW)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and memory commands
	always_comb begin
		state_d   = state_q;
		mem_we    = 1'b0;
		mem_waddr = '0;
		mem_wdata = '0;
		mem_re    = 1'b0;
		mem_raddr = '0;
		push_adv  = 1'b0;
		walk_rd   = 1'b0;
		fix_adv   = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
				if (clr_q == {AW{1'b1}}) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (s_hs) begin
					if (lo_c >= hi_c) begin
						state_d = (s_tuser == CMD_ASSIGN) ? ST_IDLE : ST_RESULT;
					end else begin
						state_d = ST_PUSH_RD;
					end
				end
			end
			ST_PUSH_RD: begin
				mem_re    = 1'b1;
				mem_raddr = AW'(push_p);
				state_d   = ST_PUSH_CHK;
			end
			ST_PUSH_CHK: begin
				if (mem_rdata.valid) begin
					mem_we          = 1'b1;
					mem_waddr       = AW'({push_p, 1'b0});
					mem_wdata.valid = (s_q != SW'(1));
					mem_wdata.tag   = mem_rdata.tag;
					mem_wdata.sum   = scaled(mem_rdata.tag, s_q - SW'(1));
					state_d         = ST_PUSH_W1;
				end else begin
					push_adv = 1'b1;
				end
			end
			ST_PUSH_W1: begin
				mem_we          = 1'b1;
				mem_waddr       = AW'({push_p, 1'b1});
				mem_wdata.valid = (s_q != SW'(1));
				mem_wdata.tag   = mem_rdata.tag;
				mem_wdata.sum   = scaled(mem_rdata.tag, s_q - SW'(1));
				state_d         = ST_PUSH_W2;
			end
			ST_PUSH_W2: begin
				mem_we          = 1'b1;
				mem_waddr       = AW'(push_p);
				mem_wdata.valid = 1'b0;
				mem_wdata.tag   = mem_rdata.tag;
				mem_wdata.sum   = mem_rdata.sum;
				push_adv        = 1'b1;
			end
			ST_WALK_L: begin
				if (l_q >= r_q) begin
					state_d = (cmd_q == CMD_ASSIGN) ? ST_FIX_RD : ST_RESULT;
				end else begin
					if (l_q[0]) begin
						if (cmd_q == CMD_ASSIGN) begin
							mem_we          = 1'b1;
							mem_waddr       = AW'(l_q);
							mem_wdata.valid = (t_q != '0);
							mem_wdata.tag   = val_q;
							mem_wdata.sum   = scaled(val_q, t_q);
						end else begin
							mem_re    = 1'b1;
							mem_raddr = AW'(l_q);
							walk_rd   = 1'b1;
						end
					end
					state_d = ST_WALK_R;
				end
			end
			ST_WALK_R: begin
				if (r_q[0]) begin
					if (cmd_q == CMD_ASSIGN) begin
						mem_we          = 1'b1;
						mem_waddr       = AW'(r_q - NW'(1));
						mem_wdata.valid = (t_q != '0);
						mem_wdata.tag   = val_q;
						mem_wdata.sum   = scaled(val_q, t_q);
					end else begin
						mem_re    = 1'b1;
						mem_raddr = AW'(r_q - NW'(1));
						walk_rd   = 1'b1;
					end
				end
				state_d = ST_WALK_L;
			end
			ST_FIX_RD: begin
				mem_re    = 1'b1;
				mem_raddr = AW'(k_q);
				state_d   = ST_FIX_CHK;
			end
			ST_FIX_CHK: begin
				if (mem_rdata.valid) begin
					fix_adv = 1'b1;
				end else begin
					mem_re    = 1'b1;
					mem_raddr = AW'({k_q, 1'b0});
					state_d   = ST_FIX_C0;
				end
			end
			ST_FIX_C0: begin
				mem_re    = 1'b1;
				mem_raddr = AW'({k_q, 1'b1});
				state_d   = ST_FIX_C1;
			end
			ST_FIX_C1: begin
				mem_we          = 1'b1;
				mem_waddr       = AW'(k_q);
				mem_wdata.valid = 1'b0;
				mem_wdata.tag   = val_q;
				mem_wdata.sum   = fix_a_q + mem_rdata.sum;
				fix_adv         = 1'b1;
			end
			ST_RESULT: begin
				if (res_load) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
		// path steps that finish a node
		if (push_adv) begin
			state_d = push_done ? ST_WALK_L : ST_PUSH_RD;
		end
		if (fix_adv) begin
			state_d = ((k_q >> 1) == '0 && pass_q) ? ST_IDLE : ST_FIX_RD;
		end
	end

	// clearing pass counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (state_q == ST_CLEAR) begin
			clr_q <= clr_q + AW'(1);
		end
	end

	// accumulator pending flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_pend_q <= 1'b0;
		end else begin
			acc_pend_q <= walk_rd;
		end
	end

	// walk, path and accumulator registers
	always_ff @(posedge clk) begin
		if (acc_pend_q) begin
			acc_q <= acc_q + mem_rdata.sum;
		end
		case (state_q)
			ST_IDLE: begin
				if (s_hs) begin
					cmd_q  <= s_tuser;
					val_q  <= in_val;
					l0_q   <= NW'(lo_c) + NW'(LEAVES);
					r0m1_q <= NW'(hi_c) + NW'(LEAVES) - NW'(1);
					k_q    <= NW'(lo_c) + NW'(LEAVES);
					s_q    <= SW'(LW);
					pass_q <= 1'b0;
					acc_q  <= '0;
				end
			end
			ST_WALK_L: begin
				if (l_q >= r_q) begin
					k_q    <= l0_q >> 1;
					pass_q <= 1'b0;
				end else if (l_q[0]) begin
					l_q <= l_q + NW'(1);
				end
			end
			ST_WALK_R: begin
				l_q <= l_q >> 1;
				r_q <= r_q >> 1;
				t_q <= t_q + SW'(1);
			end
			ST_FIX_C0: begin
				fix_a_q <= mem_rdata.sum;
			end
			default: begin
			end
		endcase
		if (push_adv) begin
			if (s_q != SW'(1)) begin
				s_q <= s_q - SW'(1);
			end else if (!pass_q) begin
				k_q    <= r0m1_q;
				s_q    <= SW'(LW);
				pass_q <= 1'b1;
			end else begin
				l_q <= l0_q;
				r_q <= r0m1_q + NW'(1);
				t_q <= '0;
			end
		end
		if (fix_adv) begin
			if ((k_q >> 1) == '0) begin
				k_q    <= r0m1_q >> 1;
				pass_q <= 1'b1;
			end else begin
				k_q <= k_q >> 1;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (res_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			m_sum_q <= acc_q;
		end
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = M_DATA_W'(m_sum_q);

	// no read of a node in the cycle it is written
	assert property (@(posedge clk) disable iff (!arst_n)
		!(mem_we && mem_re && (mem_waddr == mem_raddr)))
		else $error("node memory read and write collide");

	// no transaction during the clearing pass
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR) |-> !s_tready)
		else $error("input accepted during clearing pass");

	// partial sums only come from the range walk
	assert property (@(posedge clk) disable iff (!arst_n)
		acc_pend_q |-> (state_q == ST_WALK_L || state_q == ST_WALK_R))
		else $error("accumulate outside range walk");

	// a result is loaded only when the output register is free
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RESULT && m_tvalid && !m_tready) |=> (state_q == ST_RESULT))
		else $error("result dropped while output stalled");

endmodule
